[rtl/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants for the smallest-prime-factor core
// Holds the sequencer state encoding, the divider control struct and value width.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned VALUE_W = 16;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_INIT    = 10'b00_0000_0010,
    ST_SCAN    = 10'b00_0000_0100,
    ST_SCAN_RD = 10'b00_0000_1000,
    ST_MARK_RD = 10'b00_0001_0000,
    ST_MARK_WR = 10'b00_0010_0000,
    ST_Q_RD    = 10'b00_0100_0000,
    ST_Q_DIV   = 10'b00_1000_0000,
    ST_Q_EMIT  = 10'b01_0000_0000,
    ST_Q_WAIT  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

[rtl/spf_div.sv]
// ----------------------------------------------------------------------------
// spf_div: radix-2 restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module spf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spf_pkg::VALUE_W-1:0] dividend,
  input  logic [spf_pkg::VALUE_W-1:0] divisor,
  output spf_pkg::div_ctrl_t          ctrl,
  output logic [spf_pkg::VALUE_W-1:0] quotient
);

  localparam int unsigned W = spf_pkg::VALUE_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctrl.start = start;
  assign ctrl.busy  = busy;
  assign ctrl.done  = done;
  assign quotient   = quo;

endmodule

[rtl/smallest_prime_factor_factorizer_core.sv]
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer_core: sieve table and factoring sequencer
// Builds a smallest-prime-factor table, then factors query values.
// ----------------------------------------------------------------------------
// Usage:
//   limit_we/limit: writes the limit register at any edge and restarts the
//   table rebuild.
//   start/value: a query is transferred when start is high, busy is low and limit_we is low.
//   factor/last/status: one result per cycle that valid is high; the receiver
//   cannot stall, each result is held for exactly one cycle.
// Table build: an init sweep writes entry i = i for 2..top, then a sieve walks
//   i while i*i <= top; for each prime i it walks j = i*i, i*i+i, ... up to top
//   with a read step and a write step per j, writing only where entry j still
//   holds j. busy is high the whole time. After reset the table is built on
//   the first query.
// Query: per factor a table read, a divisor load and a divide on the single
//   divider, then the factor is emitted; a 16-bit value has at most 15 factors.
//   Out-of-range values (below 2 or above top) give one error result, in the
//   cycle right after the transfer if the table is ready, else when the build ends.
// Reset: synchronous; clears sequencer, ready flag and sets limit 65535.
//   The table memory itself is never cleared.
// ----------------------------------------------------------------------------
module smallest_prime_factor_factorizer_core #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        limit_we,
  input  logic [15:0] limit,
  input  logic        start,
  input  logic [15:0] value,
  output logic        busy,
  output logic        valid,
  output logic [15:0] factor,
  output logic        last,
  output logic        status
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned W  = spf_pkg::VALUE_W;
  // widths wide enough to hold TABLE_SIZE-1 and the larger of it and a value
  localparam int unsigned XW = (AW > W) ? AW : W;
  localparam logic [XW-1:0] TOP_MAX = XW'(TABLE_SIZE - 1);

  logic [W-1:0] mem [TABLE_SIZE];
  logic [W-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;

  spf_pkg::state_t state;
  logic [W-1:0]    limit_reg;
  logic            ready;
  logic            pend_q;     // query waiting on table build
  logic [XW-1:0]   top;
  logic [XW:0]     i_cnt;      // sieve prime / init index
  logic [XW:0]     j_cnt;      // sieve multiple
  logic [2*XW+1:0] i_sq;
  logic [W-1:0]    x;          // remaining value
  logic [W-1:0]    f;          // current factor
  logic            div_start;
  spf_pkg::div_ctrl_t dctl;
  logic [W-1:0]    quo;

  assign top  = (XW'(limit_reg) > TOP_MAX) ? TOP_MAX
                : XW'(limit_reg);
  assign i_sq = i_cnt * i_cnt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  spf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x),
    .divisor  (f),
    .ctrl     (dctl),
    .quotient (quo)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_cnt[AW-1:0];
    wr_data = W'(i_cnt);
    rd_addr = AW'(x);
    case (state)
      spf_pkg::ST_INIT:    wr_en = 1'b1;
      spf_pkg::ST_SCAN:    rd_addr = i_cnt[AW-1:0];
      spf_pkg::ST_MARK_RD: rd_addr = j_cnt[AW-1:0];
      spf_pkg::ST_MARK_WR: begin
        wr_addr = j_cnt[AW-1:0];
        wr_data = W'(i_cnt);
        wr_en   = (rd_data == W'(j_cnt));
      end
      default: ;
    endcase
  end

  assign busy = (state != spf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spf_pkg::ST_IDLE;
      limit_reg <= 16'hFFFF;
      ready     <= 1'b0;
      pend_q    <= 1'b0;
      valid     <= 1'b0;
      div_start <= 1'b0;
    end else begin
      valid     <= 1'b0;
      div_start <= 1'b0;
      if (limit_we) begin
        // a limit write restarts the table build from any state
        limit_reg <= limit;
        ready     <= 1'b0;
        pend_q    <= 1'b0;
        i_cnt     <= (XW+1)'(2);
        state     <= spf_pkg::ST_INIT;
      end else begin
        case (state)
          spf_pkg::ST_IDLE: begin
            if (start) begin
              x <= value;
              if (!ready) begin
                pend_q <= 1'b1;
                i_cnt  <= (XW+1)'(2);
                state  <= spf_pkg::ST_INIT;
              end else if (value < 16'd2 || XW'(value) > top) begin
                factor <= '0;
                last   <= 1'b1;
                status <= 1'b1;
                valid  <= 1'b1;
                state  <= spf_pkg::ST_Q_WAIT;
              end else begin
                state <= spf_pkg::ST_Q_RD;
              end
            end
          end
          spf_pkg::ST_INIT: begin
            if (i_cnt >= {1'b0, top}) begin
              i_cnt <= (XW+1)'(2);
              state <= spf_pkg::ST_SCAN;
            end else begin
              i_cnt <= i_cnt + 1'b1;
            end
          end
          spf_pkg::ST_SCAN: begin
            if (i_sq > {{(XW+2){1'b0}}, top}) begin
              ready <= 1'b1;
              if (pend_q) begin
                pend_q <= 1'b0;
                if (x < 16'd2 || XW'(x) > top) begin
                  factor <= '0;
                  last   <= 1'b1;
                  status <= 1'b1;
                  valid  <= 1'b1;
                  state  <= spf_pkg::ST_Q_WAIT;
                end else begin
                  state <= spf_pkg::ST_Q_RD;
                end
              end else begin
                state <= spf_pkg::ST_IDLE;
              end
            end else begin
              state <= spf_pkg::ST_SCAN_RD;
            end
          end
          spf_pkg::ST_SCAN_RD: begin
            if (rd_data == W'(i_cnt)) begin
              j_cnt <= (XW+1)'(i_sq);
              state <= spf_pkg::ST_MARK_RD;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              state <= spf_pkg::ST_SCAN;
            end
          end
          spf_pkg::ST_MARK_RD: begin
            if (j_cnt > {1'b0, top}) begin
              i_cnt <= i_cnt + 1'b1;
              state <= spf_pkg::ST_SCAN;
            end else begin
              state <= spf_pkg::ST_MARK_WR;
            end
          end
          spf_pkg::ST_MARK_WR: begin
            j_cnt <= j_cnt + i_cnt;
            state <= spf_pkg::ST_MARK_RD;
          end
          spf_pkg::ST_Q_RD: begin
            state <= spf_pkg::ST_Q_DIV;
          end
          spf_pkg::ST_Q_DIV: begin
            // table entries 2..top are always >= 2 once built
            f         <= (rd_data < 16'd2) ? x : rd_data;
            div_start <= 1'b1;
            state     <= spf_pkg::ST_Q_EMIT;
          end
          spf_pkg::ST_Q_EMIT: begin
            if (dctl.done) begin
              x      <= quo;
              factor <= f;
              last   <= (quo == 16'd1);
              status <= 1'b0;
              valid  <= 1'b1;
              state  <= (quo == 16'd1) ? spf_pkg::ST_Q_WAIT : spf_pkg::ST_Q_RD;
            end
          end
          spf_pkg::ST_Q_WAIT: begin
            state <= spf_pkg::ST_IDLE;
          end
          default: state <= spf_pkg::ST_IDLE;
        endcase
      end
    end
  end

endmodule
